/* sv/sgc_pkg.sv */
// ----------------------------------------------------------------------------
// Segment grid coverage package
// Shared widths, register indexes, state encodings and the control bundle
// passed from the segment walker to the mark memory.
// ----------------------------------------------------------------------------
package sgc_pkg;

   // Width of one endpoint coordinate and of a bound register.
   localparam int CRD_W = 9;
   // Walk column: one sign bit and one carry bit above the coordinate.
   localparam int WALK_W = CRD_W + 2;
   // Width of the running count of marked cells.
   localparam int CNT_W = 19;

   // Configuration port geometry.
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   // Register indexes, taken from the word address.
   localparam logic REG_LAST_ROW = 1'b0;
   localparam logic REG_LAST_COL = 1'b1;

   // Reset value of both bound registers.
   localparam logic [CRD_W-1:0] BOUND_RESET = 9'd511;

   // Segment walker states.
   typedef enum logic {
      WALK_IDLE,
      WALK_RUN
   } walk_state_type;

   // One cell issued by the walker.
   typedef struct packed {
      logic valid;   // a cell is issued this cycle
      logic hit;     // the cell lies inside bounds and store
      logic last;    // final cell of the segment
   } cell_ctrl_type;

   // Status of the mark memory for the top level.
   typedef struct packed {
      logic clearing;   // reset clearing pass is running
      logic finishing;  // last cell of a segment is being written back
      logic done;       // count for the segment is final this cycle
   } mem_status_type;

endpackage

/* sv/segment_grid_coverage.sv */
// ----------------------------------------------------------------------------
// Segment grid coverage
// Marks grid cells covered by horizontal, vertical and stepped diagonal
// segments and reports the number of distinct marked cells after each one.
// ----------------------------------------------------------------------------
// Result: after acceptance the walker issues the n cells of a segment (n = 1 to 512)
//   and the result strobe follows their write-back, for one cycle that cannot be stalled.
// Transactions: one segment in flight at a time; the mark memory performs one
//   read-modify-write per cell, and busy falls during the result strobe.
// Reset: bounds return to 511, the count to zero, and a clearing pass over all
//   2**(2*clog2(GRID_SIZE)) entries (262144 by default) holds busy high.
module segment_grid_coverage #(
   parameter int GRID_SIZE = 512
) (
   input  logic                        clock,
   input  logic                        reset,
   // Segment transactions
   input  logic                        start,
   output logic                        busy,
   input  logic [sgc_pkg::CRD_W-1:0]   req_row_start,
   input  logic [sgc_pkg::CRD_W-1:0]   req_col_start,
   input  logic [sgc_pkg::CRD_W-1:0]   req_row_end,
   input  logic [sgc_pkg::CRD_W-1:0]   req_col_end,
   // Results
   output logic                        rsp_valid,
   output logic [sgc_pkg::CNT_W-1:0]   rsp_covered_count,
   // Configuration
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [sgc_pkg::CSR_AW-1:0]  paddr,
   input  logic [sgc_pkg::CSR_DW-1:0]  pwdata,
   output logic [sgc_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready
);
   import sgc_pkg::*;

   localparam int AW = 2 * $clog2(GRID_SIZE);

   logic [CRD_W-1:0] last_row_ff, last_col_ff;
   logic             busy_ff, busy_in;
   logic             accept, csr_write;
   logic             reg_sel;
   cell_ctrl_type    cell_cmd;
   logic [AW-1:0]    cell_addr;
   mem_status_type   mem_status;
   logic [CNT_W-1:0] total;

   // Bound registers.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign reg_sel   = paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         last_row_ff <= BOUND_RESET;
         last_col_ff <= BOUND_RESET;
      end else if (csr_write) begin
         case (reg_sel)
            REG_LAST_ROW: last_row_ff <= pwdata[CRD_W-1:0];
            REG_LAST_COL: last_col_ff <= pwdata[CRD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_LAST_ROW: prdata = CSR_DW'(last_row_ff);
         REG_LAST_COL: prdata = CSR_DW'(last_col_ff);
         default:      prdata = '0;
      endcase
   end

   // Transaction interlock: one segment in flight at a time.
   assign accept = start && !busy;

   always_comb begin
      busy_in = busy_ff;
      if (accept) busy_in = 1'b1;
      else if (mem_status.finishing) busy_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff || mem_status.clearing;

   sgc_walker #(
      .GRID_SIZE (GRID_SIZE)
   ) u_walker (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .row_start (req_row_start),
      .col_start (req_col_start),
      .row_end   (req_row_end),
      .col_end   (req_col_end),
      .last_row  (last_row_ff),
      .last_col  (last_col_ff),
      .cell_cmd  (cell_cmd),
      .cell_addr (cell_addr)
   );

   sgc_mark_mem #(
      .GRID_SIZE (GRID_SIZE)
   ) u_mark_mem (
      .clock     (clock),
      .reset     (reset),
      .cell_cmd  (cell_cmd),
      .cell_addr (cell_addr),
      .status    (mem_status),
      .total     (total)
   );

   // The result strobe is registered in the cycle after the final write-back.
   assign rsp_valid         = mem_status.done;
   assign rsp_covered_count = total;

endmodule

/* sv/sgc_walker.sv */
// ----------------------------------------------------------------------------
// Segment walker
// Loads a segment at acceptance, then issues one cell per cycle with its
// bounds check and memory address until the row or column span is covered.
// ----------------------------------------------------------------------------
module sgc_walker #(
   parameter int GRID_SIZE = 512
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  logic [sgc_pkg::CRD_W-1:0]   row_start,
   input  logic [sgc_pkg::CRD_W-1:0]   col_start,
   input  logic [sgc_pkg::CRD_W-1:0]   row_end,
   input  logic [sgc_pkg::CRD_W-1:0]   col_end,
   input  logic [sgc_pkg::CRD_W-1:0]   last_row,
   input  logic [sgc_pkg::CRD_W-1:0]   last_col,
   output sgc_pkg::cell_ctrl_type      cell_cmd,
   output logic [2*$clog2(GRID_SIZE)-1:0] cell_addr
);
   import sgc_pkg::*;

   localparam int CW    = $clog2(GRID_SIZE);
   localparam int EXT_W = (CW + 1 > WALK_W) ? CW + 1 : WALK_W;

   walk_state_type      state_ff, state_in;
   logic [CRD_W-1:0]    row_ff, row_in;
   logic [WALK_W-1:0]   col_ff, col_in;
   logic                drow_ff, drow_in;
   logic [WALK_W-1:0]   dcol_ff, dcol_in;
   logic [CRD_W-1:0]    steps_ff, steps_in;

   logic                row_eq, col_eq, swap;
   logic [CRD_W-1:0]    row_lo, row_hi, col_lo_end, col_hi_end, col_min, col_max;
   logic [EXT_W-1:0]    row_ext, col_ext, grid_lim;
   logic                last_step;

   // Endpoint ordering for the three segment kinds.
   always_comb begin
      row_eq     = (row_start == row_end);
      col_eq     = (col_start == col_end);
      swap       = (row_start > row_end);
      row_lo     = swap ? row_end : row_start;
      row_hi     = swap ? row_start : row_end;
      col_lo_end = swap ? col_end : col_start;
      col_hi_end = swap ? col_start : col_end;
      col_min    = (col_start < col_end) ? col_start : col_end;
      col_max    = (col_start < col_end) ? col_end : col_start;
   end

   assign last_step = (steps_ff == '0);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         WALK_IDLE: begin
            if (load) state_in = WALK_RUN;
         end
         WALK_RUN: begin
            if (last_step) state_in = WALK_IDLE;
         end
         default: state_in = WALK_IDLE;
      endcase
   end

   // Walk registers: loaded at acceptance, stepped while running.
   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      drow_in  = drow_ff;
      dcol_in  = dcol_ff;
      steps_in = steps_ff;
      if (state_ff == WALK_IDLE && load) begin
         if (row_eq) begin
            row_in   = row_start;
            col_in   = WALK_W'(col_min);
            drow_in  = 1'b0;
            dcol_in  = WALK_W'(1);
            steps_in = col_max - col_min;
         end else if (col_eq) begin
            row_in   = row_lo;
            col_in   = WALK_W'(col_start);
            drow_in  = 1'b1;
            dcol_in  = '0;
            steps_in = row_hi - row_lo;
         end else begin
            row_in   = row_lo;
            col_in   = WALK_W'(col_lo_end);
            drow_in  = 1'b1;
            dcol_in  = (col_lo_end < col_hi_end) ? WALK_W'(1) : {WALK_W{1'b1}};
            steps_in = row_hi - row_lo;
         end
      end else if (state_ff == WALK_RUN) begin
         row_in   = row_ff + CRD_W'(drow_ff);
         col_in   = col_ff + dcol_ff;
         steps_in = steps_ff - CRD_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= WALK_IDLE;
      end else begin
         state_ff <= state_in;
      end
      row_ff   <= row_in;
      col_ff   <= col_in;
      drow_ff  <= drow_in;
      dcol_ff  <= dcol_in;
      steps_ff <= steps_in;
   end

   // Cell outputs: bounds check and address of the current cell.
   always_comb begin
      row_ext        = EXT_W'(row_ff);
      col_ext        = EXT_W'(col_ff[WALK_W-2:0]);
      grid_lim       = EXT_W'(GRID_SIZE);
      cell_cmd.valid = (state_ff == WALK_RUN);
      cell_cmd.last  = last_step;
      cell_cmd.hit   = !col_ff[WALK_W-1]
                       && (row_ext <= EXT_W'(last_row))
                       && (col_ext <= EXT_W'(last_col))
                       && (row_ext < grid_lim)
                       && (col_ext < grid_lim);
      cell_addr      = {row_ext[CW-1:0], col_ext[CW-1:0]};
   end

endmodule

/* sv/sgc_mark_mem.sv */
// ----------------------------------------------------------------------------
// Mark memory
// One-bit-per-cell store with a registered read. Each issued cell
// is read, and if it is inside bounds and still clear it is set on the next
// cycle and the running count advances. A clearing pass sweeps the store
// after reset.
// ----------------------------------------------------------------------------
module sgc_mark_mem #(
   parameter int GRID_SIZE = 512
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sgc_pkg::cell_ctrl_type         cell_cmd,
   input  logic [2*$clog2(GRID_SIZE)-1:0] cell_addr,
   output sgc_pkg::mem_status_type        status,
   output logic [sgc_pkg::CNT_W-1:0]      total
);
   import sgc_pkg::*;

   localparam int AW    = 2 * $clog2(GRID_SIZE);
   localparam int DEPTH = 1 << AW;

   logic             mark_mem_ff [DEPTH];
   logic             rd_bit_ff;
   cell_ctrl_type    s1_ff;
   logic [AW-1:0]    s1_addr_ff;
   logic             clr_active_ff;
   logic [AW-1:0]    clr_addr_ff;
   logic [CNT_W-1:0] total_ff, total_in;
   logic             done_ff;

   logic             set_bit, wr_en, wr_data;
   logic [AW-1:0]    wr_addr;

   // Write-back stage: set a clear in-bounds cell, or clear during the sweep.
   always_comb begin
      set_bit  = s1_ff.valid && s1_ff.hit && !rd_bit_ff;
      wr_en    = clr_active_ff || set_bit;
      wr_addr  = clr_active_ff ? clr_addr_ff : s1_addr_ff;
      wr_data  = !clr_active_ff;
      total_in = total_ff + CNT_W'(set_bit);
   end

   // Storage: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mark_mem_ff[wr_addr] <= wr_data;
      end
      rd_bit_ff <= mark_mem_ff[cell_addr];
   end

   // Read stage to write-back stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else begin
         s1_ff <= cell_cmd;
      end
      s1_addr_ff <= cell_addr;
   end

   // Clearing sweep after reset, one entry per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == {AW{1'b1}}) clr_active_ff <= 1'b0;
      end
   end

   // Running count and segment completion.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         total_ff <= total_in;
         done_ff  <= s1_ff.valid && s1_ff.last;
      end
   end

   always_comb begin
      status.clearing  = clr_active_ff;
      status.finishing = s1_ff.valid && s1_ff.last;
      status.done      = done_ff;
      total            = total_ff;
   end

endmodule

/* sv/sgc_checker.sv */
// ----------------------------------------------------------------------------
// Segment grid coverage checker
// Port-level properties of the transaction and result timing, bound to the
// top level.
// ----------------------------------------------------------------------------
module sgc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_valid,
   input logic [sgc_pkg::CNT_W-1:0] rsp_covered_count
);
   import sgc_pkg::*;

   // An accepted transaction makes the block busy on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after an accepted transaction");

   // A result strobe lasts a single cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // A result ends the busy period: the block was busy and is free now.
   a_result_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(busy))
      else $error("result strobe not aligned with the end of busy");

   // The reported count is a defined value whenever it is shown.
   a_count_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_covered_count))
      else $error("result count unknown at strobe");

endmodule

bind segment_grid_coverage sgc_checker u_sgc_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_covered_count (rsp_covered_count)
);
